### rtl/core/sio_cfg_pkg.sv
// Types and constants shared by the super I/O configuration decoder.
package sio_cfg_pkg;

  localparam int unsigned NUM_REGS = 29;
  localparam int unsigned IDX_W    = 5;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] port_addr;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_hit;
    logic [9:0] lpt_base;
    logic [9:0] uart1_base;
    logic [2:0] uart1_irq;
    logic [9:0] uart2_base;
    logic [2:0] uart2_irq;
    logic [9:0] fdc_base;
    logic       fdc_enhanced;
    logic       fdc_densel_polarity;
    logic [9:0] gpio_base;
    logic [1:0] gpio_enables;
  } rsp_t;

  // register numbers
  localparam logic [IDX_W-1:0] REG_ENABLE   = 5'h00;
  localparam logic [IDX_W-1:0] REG_ADDR     = 5'h01;
  localparam logic [IDX_W-1:0] REG_PWRDN    = 5'h02;
  localparam logic [IDX_W-1:0] REG_ID       = 5'h08;
  localparam logic [IDX_W-1:0] REG_FDC      = 5'h09;
  localparam logic [IDX_W-1:0] REG_GPIO_BA  = 5'h0F;
  localparam logic [IDX_W-1:0] REG_GPIO_EN  = 5'h12;
  localparam logic [IDX_W-1:0] REG_LPT_BA   = 5'h19;
  localparam logic [IDX_W-1:0] REG_LPT_CTL  = 5'h1B;
  localparam logic [IDX_W-1:0] REG_PNP      = 5'h1C;

  localparam logic [7:0] ID_VALUE      = 8'h70;
  localparam logic [7:0] ENABLE_MAGIC  = 8'h08;
  localparam logic [7:0] ENABLE_SUBST  = 8'h4B;
  localparam logic [7:0] ENABLE_MASK   = 8'h5F;
  localparam logic [7:0] LPT_BA_RELOAD = 8'hEF;
  localparam logic [7:0] LPT_CTL_MODE  = 8'h70;

  localparam logic [9:0] LPT_PRI  = 10'h378;
  localparam logic [9:0] LPT_SEC  = 10'h278;
  localparam logic [9:0] COM1_BA  = 10'h3F8;
  localparam logic [9:0] COM2_BA  = 10'h2F8;
  localparam logic [9:0] FDC_PRI  = 10'h3F0;
  localparam logic [9:0] FDC_SEC  = 10'h370;
  localparam logic [2:0] IRQ3     = 3'd3;
  localparam logic [2:0] IRQ4     = 3'd4;

  localparam logic [9:0] UART_ALT3 [4] = '{10'h3E8, 10'h338, 10'h2E8, 10'h220};
  localparam logic [9:0] UART_ALT4 [4] = '{10'h2E8, 10'h238, 10'h2E0, 10'h228};

  localparam logic [7:0] CFG_RESET [NUM_REGS] = '{
    8'h0B, 8'h01, 8'h00, 8'h01, 8'h00, 8'h0D, 8'h00, 8'h00,
    8'h70, 8'hC0, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h1E,
    8'h00, 8'h00, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'hEF, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] GPIO0_RESET = 8'hFF;
  localparam logic [7:0] GPIO1_RESET = 8'hFB;

endpackage

### rtl/core/super_io_config_decoder_top.sv
// Super I/O index/data configuration registers with resource decode, top level.
//
// One bus access is taken per beat and answered in the next cycle with the read
// byte and the full resource decode (printer, two UARTs, floppy, GPIO pair)
// as it stands after that access. Throughput is one access per clock: the
// register file update and the decode sit between the state registers and a
// single output register, and a new access is taken whenever that register
// is empty or is being drained. The index port is CONFIG_PORT, the data port
// CONFIG_PORT+1; a data write lands only on the second consecutive data write,
// and any config-port read disarms it. Reset loads the register defaults.
module super_io_config_decoder_top
  import sio_cfg_pkg::*;
#(
  parameter int unsigned CONFIG_PORT = 46
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam logic [15:0] IDX_PORT = 16'(CONFIG_PORT);
  localparam logic [15:0] DAT_PORT = 16'(CONFIG_PORT + 1);

  logic [7:0]       cfg [NUM_REGS];
  logic [7:0]       cfg_next [NUM_REGS];
  logic [IDX_W-1:0] reg_index, reg_index_next;
  logic             write_armed, write_armed_next;
  logic [7:0]       gpio [2];
  logic [7:0]       gpio_next [2];
  rsp_t             rsp_next;

  logic       accept;
  logic [9:0] gbase_cur;
  logic [1:0] gen_cur;
  logic       g0_hit, g1_hit;
  logic       idx_ok;
  logic [7:0] wval;
  logic [7:0] diff;
  logic       pd;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  function automatic logic [9:0] uart_base(logic en, logic [1:0] sel, logic [1:0] hi);
    logic [9:0] b;
    case (sel)
      2'd0:    b = COM1_BA;
      2'd1:    b = COM2_BA;
      2'd2:    b = UART_ALT3[hi];
      default: b = UART_ALT4[hi];
    endcase
    return en ? b : 10'd0;
  endfunction

  function automatic logic [2:0] uart_irq(logic pnp_en, logic pnp, logic fer);
    if (pnp_en) return pnp ? IRQ4 : IRQ3;
    return fer ? IRQ3 : IRQ4;
  endfunction

  function automatic logic [9:0] lpt_decode(logic [7:0] r0, logic [7:0] r1,
                                            logic [7:0] r19, logic [7:0] r1b);
    logic [9:0] b;
    if (!r0[0]) begin
      b = 10'd0;
    end else if (r1b[4]) begin
      b = r1b[5] ? LPT_SEC : LPT_PRI;
    end else begin
      case (r1[1:0])
        2'd0:    b = LPT_PRI;
        2'd1:    b = {r19, 2'b00};
        2'd2:    b = LPT_SEC;
        default: b = 10'd0;
      endcase
    end
    return b;
  endfunction

  assign gbase_cur = {cfg[REG_GPIO_BA], 2'b00};
  assign gen_cur   = cfg[REG_GPIO_EN][5:4];
  assign g0_hit    = gen_cur[0] && (req.port_addr == {6'd0, gbase_cur});
  assign g1_hit    = gen_cur[1] && (req.port_addr == 16'({1'b0, gbase_cur} + 11'd1));
  assign idx_ok    = reg_index < IDX_W'(NUM_REGS);
  assign wval      = (reg_index == REG_ENABLE && req.write_data == ENABLE_MAGIC)
                     ? ENABLE_SUBST : req.write_data;
  assign diff      = idx_ok ? (wval ^ cfg[reg_index]) : 8'd0;

  always_comb begin
    cfg_next            = cfg;
    reg_index_next      = reg_index;
    write_armed_next    = write_armed;
    gpio_next           = gpio;
    rsp_next            = '0;
    rsp_next.read_data  = (req.cmd == CMD_WRITE) ? 8'h00 : 8'hFF;
    rsp_next.read_hit   = 1'b0;
    if (accept) begin
      if (req.port_addr == IDX_PORT) begin
        write_armed_next = 1'b0;
        if (req.cmd == CMD_WRITE) begin
          reg_index_next = req.write_data[IDX_W-1:0];
        end else begin
          rsp_next.read_data = {3'd0, reg_index};
          rsp_next.read_hit  = 1'b1;
        end
      end else if (req.port_addr == DAT_PORT) begin
        if (req.cmd == CMD_WRITE) begin
          write_armed_next = !write_armed;
          if (write_armed && idx_ok && reg_index != REG_ID &&
              !(reg_index == REG_LPT_BA && !cfg[REG_LPT_CTL][6])) begin
            cfg_next[reg_index] = (reg_index == REG_ENABLE) ? (wval & ENABLE_MASK) : wval;
            if (reg_index == REG_LPT_CTL && (diff & LPT_CTL_MODE) != 8'd0 && !wval[6]) begin
              cfg_next[REG_LPT_BA] = LPT_BA_RELOAD;
            end
          end
        end else begin
          write_armed_next   = 1'b0;
          rsp_next.read_hit  = 1'b1;
          if (reg_index == REG_ID) begin
            rsp_next.read_data = ID_VALUE;
          end else if (idx_ok) begin
            rsp_next.read_data = cfg[reg_index];
          end else begin
            rsp_next.read_data = 8'hFF;
          end
        end
      end else if (g0_hit || g1_hit) begin
        if (req.cmd == CMD_WRITE) begin
          gpio_next[req.port_addr[0]] = req.write_data;
        end else begin
          rsp_next.read_data = gpio[req.port_addr[0]];
          rsp_next.read_hit  = 1'b1;
        end
      end
    end

    pd = cfg_next[REG_PWRDN][0];
    rsp_next.lpt_base = pd ? 10'd0 : lpt_decode(cfg_next[REG_ENABLE], cfg_next[REG_ADDR],
                                                 cfg_next[REG_LPT_BA], cfg_next[REG_LPT_CTL]);
    rsp_next.uart1_base = pd ? 10'd0 : uart_base(cfg_next[REG_ENABLE][1],
                                                  cfg_next[REG_ADDR][3:2],
                                                  cfg_next[REG_ADDR][7:6]);
    rsp_next.uart2_base = pd ? 10'd0 : uart_base(cfg_next[REG_ENABLE][2],
                                                  cfg_next[REG_ADDR][5:4],
                                                  cfg_next[REG_ADDR][7:6]);
    rsp_next.uart1_irq = uart_irq(cfg_next[REG_PNP][0], cfg_next[REG_PNP][2],
                                  cfg_next[REG_ADDR][2]);
    rsp_next.uart2_irq = uart_irq(cfg_next[REG_PNP][0], cfg_next[REG_PNP][6],
                                  cfg_next[REG_ADDR][4]);
    rsp_next.fdc_base = (pd || !cfg_next[REG_ENABLE][3]) ? 10'd0
                        : (cfg_next[REG_ENABLE][5] ? FDC_SEC : FDC_PRI);
    rsp_next.fdc_enhanced        = cfg_next[REG_FDC][2];
    rsp_next.fdc_densel_polarity = cfg_next[REG_FDC][6];
    rsp_next.gpio_base           = {cfg_next[REG_GPIO_BA], 2'b00};
    rsp_next.gpio_enables        = cfg_next[REG_GPIO_EN][5:4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg         <= CFG_RESET;
      reg_index   <= '0;
      write_armed <= 1'b0;
      gpio[0]     <= GPIO0_RESET;
      gpio[1]     <= GPIO1_RESET;
      rsp_valid   <= 1'b0;
    end else begin
      cfg         <= cfg_next;
      reg_index   <= reg_index_next;
      write_armed <= write_armed_next;
      gpio        <= gpio_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  a_accept_gives_beat: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted access produced no response beat");

  a_write_reads_zero: assert property (@(posedge clk) disable iff (rst)
    accept && req.cmd == CMD_WRITE |=> rsp.read_data == 8'h00 && !rsp.read_hit)
    else $error("write returned read data");

  a_powerdown_off: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && cfg[REG_PWRDN][0] |->
      rsp.lpt_base == 10'd0 && rsp.uart1_base == 10'd0 &&
      rsp.uart2_base == 10'd0 && rsp.fdc_base == 10'd0)
    else $error("resource decoded during power-down");

  a_index_write_disarms: assert property (@(posedge clk) disable iff (rst)
    accept && req.port_addr == IDX_PORT |=> !write_armed)
    else $error("index port access left data write armed");

  a_index_read: assert property (@(posedge clk) disable iff (rst)
    accept && req.port_addr == IDX_PORT && req.cmd == CMD_READ |=>
      rsp.read_hit && rsp.read_data[7:5] == 3'd0)
    else $error("bad index port read");

endmodule
